>>> rtl/ust_pkg.sv
package ust_pkg;

  localparam int CAPACITY      = 256;
  localparam int ADDR_W        = $clog2(CAPACITY);
  localparam int COUNT_W       = $clog2(CAPACITY + 1);
  localparam int KIND_W        = 2;
  localparam int IDENT_W       = 27;
  localparam int STATUS_W      = 3;
  localparam int ENTRY_COUNT_W = 9;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED    = 3'd0,
    ST_FULL        = 3'd1,
    ST_FOUND       = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_EMPTY       = 3'd4,
    ST_REMOVED     = 3'd5,
    ST_REMOVE_MISS = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_SREAD,
    S_SWRITE,
    S_RESP
  } state_t;

endpackage

>>> rtl/unsorted_id_set_table.sv
// channel   signals                         handshake
// command   start, kind[1:0], ident[26:0]   taken when start && !busy
// result    done, status[2:0], entry_count  done high for one cycle, no stall
//
// insert: the ident is written at the end of the list as the command is taken, then done
// lookup: reads and compares entries from the first on, until a hit or the last entry
// remove: scan as lookup, then each later entry is read and written one place down
// every step makes one entry access through the ram, whose read is registered
// rst (synchronous) empties the list; ram contents are left as they are
// busy stays high from acceptance through the done cycle
module unsorted_id_set_table
  import ust_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [KIND_W-1:0]        kind,
  input  logic [IDENT_W-1:0]       ident,
  output logic                     busy,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic [ENTRY_COUNT_W-1:0] entry_count
);

  state_t             state;
  state_t             state_next;
  kind_t              op;
  logic [IDENT_W-1:0] key;
  logic [ADDR_W-1:0]  ptr;
  logic [COUNT_W-1:0] count;
  status_t            result;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [IDENT_W-1:0] wdata;
  logic [ADDR_W-1:0]  raddr;
  logic [IDENT_W-1:0] rdata;

  logic               hit;
  logic               last;
  logic               shift_end;
  logic               room;

  assign hit       = (rdata == key);
  assign last      = ((COUNT_W'(ptr) + COUNT_W'(1)) == count);
  assign shift_end = ((COUNT_W'(ptr) + COUNT_W'(2)) >= count);
  assign room      = (count < COUNT_W'(CAPACITY));

  ust_ram #(
    .WIDTH(IDENT_W),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (kind_t'(kind))
            KIND_LOOKUP, KIND_REMOVE: begin
              state_next = (count == '0) ? S_RESP : S_READ;
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (hit && op == KIND_REMOVE && !last) begin
          state_next = S_SREAD;
        end else if (hit || last) begin
          state_next = S_RESP;
        end else begin
          state_next = S_READ;
        end
      end
      S_SREAD: begin
        state_next = S_SWRITE;
      end
      S_SWRITE: begin
        state_next = shift_end ? S_RESP : S_SREAD;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs and ram control
  always_comb begin
    busy  = (state != S_IDLE);
    done  = (state == S_RESP);
    we    = 1'b0;
    waddr = ptr;
    wdata = rdata;
    raddr = ptr;
    unique case (state)
      S_IDLE: begin
        we    = start && (kind_t'(kind) == KIND_INSERT) && room;
        waddr = count[ADDR_W-1:0];
        wdata = ident;
      end
      S_SREAD: begin
        raddr = ptr + ADDR_W'(1);
      end
      S_SWRITE: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign status      = result;
  assign entry_count = ENTRY_COUNT_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op  <= kind_t'(kind);
            key <= ident;
            ptr <= '0;
            case (kind_t'(kind))
              KIND_INSERT: begin
                if (room) begin
                  count  <= count + COUNT_W'(1);
                  result <= ST_INSERTED;
                end else begin
                  result <= ST_FULL;
                end
              end
              KIND_LOOKUP, KIND_REMOVE: begin
                result <= ST_EMPTY;
              end
              default: begin
                result <= ST_NOT_FOUND;
              end
            endcase
          end
        end
        S_CMP: begin
          if (hit) begin
            if (op == KIND_LOOKUP) begin
              result <= ST_FOUND;
            end else if (last) begin
              count  <= count - COUNT_W'(1);
              result <= ST_REMOVED;
            end
          end else if (last) begin
            result <= (op == KIND_LOOKUP) ? ST_NOT_FOUND : ST_REMOVE_MISS;
          end else begin
            ptr <= ptr + ADDR_W'(1);
          end
        end
        S_SWRITE: begin
          ptr <= ptr + ADDR_W'(1);
          if (shift_end) begin
            count  <= count - COUNT_W'(1);
            result <= ST_REMOVED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_count_at_done: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> done)
    else $error("count changed outside a result cycle");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP || state == S_SREAD) |-> (COUNT_W'(ptr) < count))
    else $error("scan pointer past end of list");

endmodule

>>> rtl/ust_ram.sv
module ust_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
